[rtl/fzm_pkg.sv]
`timescale 1ns / 1ps

package fzm_pkg;

   localparam int SAMPLE_BITS_DEFAULT   = 16;
   localparam int FRACTION_BITS_DEFAULT = 15;
   localparam int LANE_COUNT            = 5;
   localparam int CSR_INDEX_BITS        = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_BREAK_ONE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BREAK_TWO   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BREAK_THREE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BREAK_FOUR  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BREAK_FIVE  = 3'd4;

   localparam logic [31:0] BREAK_ONE_RESET   = 32'd10000;
   localparam logic [31:0] BREAK_TWO_RESET   = 32'd20000;
   localparam logic [31:0] BREAK_THREE_RESET = 32'd30000;
   localparam logic [31:0] BREAK_FOUR_RESET  = 32'd40000;
   localparam logic [31:0] BREAK_FIVE_RESET  = 32'd50000;

   // what a lane delivers once the divider chain is done
   typedef enum logic [1:0] {
      MODE_ZERO = 2'b00,
      MODE_ONE  = 2'b01,
      MODE_DIV  = 2'b10
   } fzm_mode_type;

   typedef struct packed {
      logic                          valid;
      fzm_mode_type [LANE_COUNT-1:0] mode;
   } fzm_ctrl_type;

endpackage

[rtl/fzm_select.sv]
`timescale 1ns / 1ps

module fzm_select #(
   parameter int SAMPLE_BITS = fzm_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     sample_valid,
   input  logic [SAMPLE_BITS-1:0]   sample,
   input  logic [SAMPLE_BITS-1:0]   brk [fzm_pkg::LANE_COUNT],
   output fzm_pkg::fzm_ctrl_type    ctrl_ff,
   output logic [SAMPLE_BITS-1:0]   rem_ff [fzm_pkg::LANE_COUNT],
   output logic [SAMPLE_BITS-1:0]   den_ff [fzm_pkg::LANE_COUNT]
);

   localparam int LANES = fzm_pkg::LANE_COUNT;

   fzm_pkg::fzm_ctrl_type  ctrl_in;
   logic [SAMPLE_BITS-1:0] rem_in [LANES];
   logic [SAMPLE_BITS-1:0] den_in [LANES];

   always_comb begin
      ctrl_in.valid = sample_valid;
      for (int l = 0; l < LANES; l++) begin
         ctrl_in.mode[l] = fzm_pkg::MODE_ZERO;
         rem_in[l]       = '0;
         den_in[l]       = '0;
      end

      // left shoulder: zero sample stays at zero
      if (sample != '0 && sample <= brk[0]) begin
         ctrl_in.mode[0] = fzm_pkg::MODE_ONE;
      end else if (sample > brk[0] && sample < brk[1]) begin
         ctrl_in.mode[0] = fzm_pkg::MODE_DIV;
         rem_in[0]       = brk[1] - sample;
         den_in[0]       = brk[1] - brk[0];
      end

      // triangles; the peak itself is a full one
      for (int l = 1; l < LANES - 1; l++) begin
         if (sample <= brk[l-1]) begin
            ctrl_in.mode[l] = fzm_pkg::MODE_ZERO;
         end else if (sample < brk[l]) begin
            ctrl_in.mode[l] = fzm_pkg::MODE_DIV;
            rem_in[l]       = sample - brk[l-1];
            den_in[l]       = brk[l] - brk[l-1];
         end else if (sample == brk[l]) begin
            ctrl_in.mode[l] = fzm_pkg::MODE_ONE;
         end else if (sample < brk[l+1]) begin
            ctrl_in.mode[l] = fzm_pkg::MODE_DIV;
            rem_in[l]       = brk[l+1] - sample;
            den_in[l]       = brk[l+1] - brk[l];
         end
      end

      // right shoulder
      if (sample <= brk[LANES-2]) begin
         ctrl_in.mode[LANES-1] = fzm_pkg::MODE_ZERO;
      end else if (sample < brk[LANES-1]) begin
         ctrl_in.mode[LANES-1] = fzm_pkg::MODE_DIV;
         rem_in[LANES-1]       = sample - brk[LANES-2];
         den_in[LANES-1]       = brk[LANES-1] - brk[LANES-2];
      end else begin
         ctrl_in.mode[LANES-1] = fzm_pkg::MODE_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         den_ff <= den_in;
      end
   end

endmodule

[rtl/fzm_div_stage.sv]
`timescale 1ns / 1ps

// One restoring step for all lanes: one quotient bit per stage.
module fzm_div_stage #(
   parameter int SAMPLE_BITS   = fzm_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = fzm_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  fzm_pkg::fzm_ctrl_type    prev_ctrl,
   input  logic [SAMPLE_BITS-1:0]   prev_rem [fzm_pkg::LANE_COUNT],
   input  logic [SAMPLE_BITS-1:0]   prev_den [fzm_pkg::LANE_COUNT],
   input  logic [FRACTION_BITS-1:0] prev_quo [fzm_pkg::LANE_COUNT],
   output fzm_pkg::fzm_ctrl_type    ctrl_ff,
   output logic [SAMPLE_BITS-1:0]   rem_ff [fzm_pkg::LANE_COUNT],
   output logic [SAMPLE_BITS-1:0]   den_ff [fzm_pkg::LANE_COUNT],
   output logic [FRACTION_BITS-1:0] quo_ff [fzm_pkg::LANE_COUNT]
);

   localparam int LANES = fzm_pkg::LANE_COUNT;

   logic [SAMPLE_BITS:0]     shifted [LANES];
   logic                     fits    [LANES];
   logic [SAMPLE_BITS-1:0]   rem_in  [LANES];
   logic [FRACTION_BITS-1:0] quo_in  [LANES];

   // remainder stays below the divisor, so the shifted value needs one bit more
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         shifted[l] = {prev_rem[l], 1'b0};
         fits[l]    = shifted[l] >= {1'b0, prev_den[l]};
         rem_in[l]  = fits[l] ? SAMPLE_BITS'(shifted[l] - {1'b0, prev_den[l]})
                              : SAMPLE_BITS'(shifted[l]);
         quo_in[l]  = {prev_quo[l][FRACTION_BITS-2:0], fits[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= prev_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         den_ff <= prev_den;
         quo_ff <= quo_in;
      end
   end

endmodule

[rtl/fzm_out_buf.sv]
`timescale 1ns / 1ps

// Output register plus skid stage; skid_full_ff holds the pipeline.
module fzm_out_buf #(
   parameter int FRACTION_BITS = fzm_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fzm_pkg::fzm_ctrl_type    last_ctrl,
   input  logic [FRACTION_BITS-1:0] last_quo [fzm_pkg::LANE_COUNT],
   input  logic                     rsp_stall,
   output logic                     out_valid_ff,
   output logic [FRACTION_BITS:0]   out_deg_ff [fzm_pkg::LANE_COUNT],
   output logic                     skid_full_ff
);

   localparam int LANES = fzm_pkg::LANE_COUNT;
   localparam logic [FRACTION_BITS:0] DEGREE_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   logic                   pipe_valid;
   logic                   out_free;
   logic [FRACTION_BITS:0] deg_new     [LANES];
   logic [FRACTION_BITS:0] skid_deg_ff [LANES];
   logic [FRACTION_BITS:0] skid_deg_in [LANES];
   logic [FRACTION_BITS:0] out_deg_in  [LANES];
   logic                   out_valid_in;
   logic                   skid_full_in;

   assign pipe_valid = last_ctrl.valid && !skid_full_ff;
   assign out_free   = !out_valid_ff || !rsp_stall;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         case (last_ctrl.mode[l])
            fzm_pkg::MODE_ONE:  deg_new[l] = DEGREE_ONE;
            fzm_pkg::MODE_DIV:  deg_new[l] = {1'b0, last_quo[l]};
            fzm_pkg::MODE_ZERO: deg_new[l] = '0;
            default:            deg_new[l] = '0;
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_deg_in   = out_deg_ff;
      skid_full_in = skid_full_ff;
      skid_deg_in  = skid_deg_ff;
      if (out_free) begin
         if (skid_full_ff) begin
            out_valid_in = 1'b1;
            out_deg_in   = skid_deg_ff;
            skid_full_in = 1'b0;
         end else begin
            out_valid_in = pipe_valid;
            out_deg_in   = deg_new;
         end
      end else if (pipe_valid) begin
         // beat arrives while the output beat is held
         skid_full_in = 1'b1;
         skid_deg_in  = deg_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      out_deg_ff  <= out_deg_in;
      skid_deg_ff <= skid_deg_in;
   end

endmodule

[rtl/five_set_fuzzy_membership_top.sv]
`timescale 1ns / 1ps

// Stages from an accepted sample to its result:
// one selection stage, one divider stage per quotient bit, one output register.
// One sample per cycle unless stalled; five restoring dividers form a pipelined chain.
// Reset (synchronous, active high) empties the pipeline and loads breakpoints
// 10000, 20000, 30000, 40000 and 50000.
module five_set_fuzzy_membership_top #(
   parameter int SAMPLE_BITS   = fzm_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = fzm_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [FRACTION_BITS:0]              rsp_degree_first,
   output logic [FRACTION_BITS:0]              rsp_degree_second,
   output logic [FRACTION_BITS:0]              rsp_degree_third,
   output logic [FRACTION_BITS:0]              rsp_degree_fourth,
   output logic [FRACTION_BITS:0]              rsp_degree_fifth,
   input  logic                                csr_write,
   input  logic [fzm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [SAMPLE_BITS-1:0]              csr_data
);

   localparam int LANES  = fzm_pkg::LANE_COUNT;
   localparam int STAGES = FRACTION_BITS;
   localparam logic [FRACTION_BITS:0] DEGREE_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   logic [SAMPLE_BITS-1:0]   brk_ff [LANES];
   logic [SAMPLE_BITS-1:0]   brk_in [LANES];

   fzm_pkg::fzm_ctrl_type    ctrl_pipe [STAGES+1];
   logic [SAMPLE_BITS-1:0]   rem_pipe  [STAGES+1][LANES];
   logic [SAMPLE_BITS-1:0]   den_pipe  [STAGES+1][LANES];
   logic [FRACTION_BITS-1:0] quo_pipe  [STAGES+1][LANES];

   logic                     advance;
   logic                     skid_full;
   logic [FRACTION_BITS:0]   out_deg [LANES];

   always_comb begin
      brk_in = brk_ff;
      if (csr_write) begin
         case (csr_index)
            fzm_pkg::REG_BREAK_ONE:   brk_in[0] = csr_data;
            fzm_pkg::REG_BREAK_TWO:   brk_in[1] = csr_data;
            fzm_pkg::REG_BREAK_THREE: brk_in[2] = csr_data;
            fzm_pkg::REG_BREAK_FOUR:  brk_in[3] = csr_data;
            fzm_pkg::REG_BREAK_FIVE:  brk_in[4] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brk_ff[0] <= SAMPLE_BITS'(fzm_pkg::BREAK_ONE_RESET);
         brk_ff[1] <= SAMPLE_BITS'(fzm_pkg::BREAK_TWO_RESET);
         brk_ff[2] <= SAMPLE_BITS'(fzm_pkg::BREAK_THREE_RESET);
         brk_ff[3] <= SAMPLE_BITS'(fzm_pkg::BREAK_FOUR_RESET);
         brk_ff[4] <= SAMPLE_BITS'(fzm_pkg::BREAK_FIVE_RESET);
      end else begin
         brk_ff <= brk_in;
      end
   end

   assign advance   = !skid_full;
   assign req_stall = skid_full;

   fzm_select #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_select (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .sample_valid (req_valid),
      .sample       (req_sample),
      .brk          (brk_ff),
      .ctrl_ff      (ctrl_pipe[0]),
      .rem_ff       (rem_pipe[0]),
      .den_ff       (den_pipe[0])
   );

   generate
      for (genvar l = 0; l < LANES; l++) begin : g_quo_seed
         assign quo_pipe[0][l] = '0;
      end

      for (genvar s = 0; s < STAGES; s++) begin : g_div
         fzm_div_stage #(
            .SAMPLE_BITS   (SAMPLE_BITS),
            .FRACTION_BITS (FRACTION_BITS)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .prev_ctrl (ctrl_pipe[s]),
            .prev_rem  (rem_pipe[s]),
            .prev_den  (den_pipe[s]),
            .prev_quo  (quo_pipe[s]),
            .ctrl_ff   (ctrl_pipe[s+1]),
            .rem_ff    (rem_pipe[s+1]),
            .den_ff    (den_pipe[s+1]),
            .quo_ff    (quo_pipe[s+1])
         );
      end
   endgenerate

   fzm_out_buf #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_out_buf (
      .clock        (clock),
      .reset        (reset),
      .last_ctrl    (ctrl_pipe[STAGES]),
      .last_quo     (quo_pipe[STAGES]),
      .rsp_stall    (rsp_stall),
      .out_valid_ff (rsp_valid),
      .out_deg_ff   (out_deg),
      .skid_full_ff (skid_full)
   );

   assign rsp_degree_first  = out_deg[0];
   assign rsp_degree_second = out_deg[1];
   assign rsp_degree_third  = out_deg[2];
   assign rsp_degree_fourth = out_deg[3];
   assign rsp_degree_fifth  = out_deg[4];

   // a held skid beat implies a held output beat
   a_skid_needs_out : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid full with no output beat");

   a_skid_fill_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("skid filled without a stalled output beat");

   a_degree_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_degree_first <= DEGREE_ONE && rsp_degree_second <= DEGREE_ONE
                  && rsp_degree_third <= DEGREE_ONE && rsp_degree_fourth <= DEGREE_ONE
                  && rsp_degree_fifth <= DEGREE_ONE))
      else $error("membership degree above one");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int SB             = fzm_pkg::SAMPLE_BITS_DEFAULT;
   localparam int FB             = fzm_pkg::FRACTION_BITS_DEFAULT;
   localparam int LANE_COUNT     = fzm_pkg::LANE_COUNT;
   localparam int CSR_INDEX_BITS = fzm_pkg::CSR_INDEX_BITS;
   localparam int LATENCY        = FB + 2;
   localparam int LIMIT          = 100000;
   localparam int HOLD_LONG      = 100;

   typedef logic [CSR_INDEX_BITS-1:0]     index_type;
   typedef logic [SB-1:0]                 sample_type;
   typedef logic [FB:0]                   degree_type;
   typedef logic [LANE_COUNT-1:0][FB:0]   degree_set_type;
   typedef logic [LANE_COUNT-1:0][SB-1:0] break_set_type;

   localparam index_type REG_SPARE_FIRST = fzm_pkg::REG_BREAK_FIVE + 1'b1;
   localparam index_type REG_SPARE_LAST  = '1;

   localparam degree_type DEGREE_ONE = degree_type'(1 << FB);

   class membership_scoreboard;
      sample_type     breakpoint [LANE_COUNT];
      degree_set_type expected_degrees [$];
      int             mismatch_count;
      string          lane_name [LANE_COUNT] = '{"first", "second", "third", "fourth", "fifth"};

      function new();
         breakpoint[0]  = fzm_pkg::BREAK_ONE_RESET[SB-1:0];
         breakpoint[1]  = fzm_pkg::BREAK_TWO_RESET[SB-1:0];
         breakpoint[2]  = fzm_pkg::BREAK_THREE_RESET[SB-1:0];
         breakpoint[3]  = fzm_pkg::BREAK_FOUR_RESET[SB-1:0];
         breakpoint[4]  = fzm_pkg::BREAK_FIVE_RESET[SB-1:0];
         mismatch_count = 0;
      endfunction

      function void write_break(index_type idx, sample_type value);
         // spare indexes are dropped by the block
         if (idx <= fzm_pkg::REG_BREAK_FIVE) breakpoint[idx] = value;
      endfunction

      // callers guarantee 0 <= num <= den
      function degree_type frac_of(bit [63:0] num, bit [63:0] den);
         if (den == 0) return '0;
         return degree_type'((num << FB) / den);
      endfunction

      function degree_type tri_degree(bit [63:0] x, bit [63:0] lo, bit [63:0] peak,
                                      bit [63:0] hi);
         if (x <= lo) return '0;
         if (x <= peak) return frac_of(x - lo, peak - lo);
         if (x < hi) return frac_of(hi - x, hi - peak);
         return '0;
      endfunction

      function degree_type left_degree(bit [63:0] x, bit [63:0] a, bit [63:0] b);
         // zero sample sits outside the full region
         if (x > 0 && x <= a) return DEGREE_ONE;
         if (x > a && x < b) return frac_of(b - x, b - a);
         return '0;
      endfunction

      function degree_type right_degree(bit [63:0] x, bit [63:0] d, bit [63:0] e);
         if (x <= d) return '0;
         if (x < e) return frac_of(x - d, e - d);
         return DEGREE_ONE;
      endfunction

      function void note_sample(sample_type x);
         degree_set_type deg;
         bit [63:0]      xv;
         xv     = x;
         deg[0] = left_degree(xv, breakpoint[0], breakpoint[1]);
         deg[1] = tri_degree(xv, breakpoint[0], breakpoint[1], breakpoint[2]);
         deg[2] = tri_degree(xv, breakpoint[1], breakpoint[2], breakpoint[3]);
         deg[3] = tri_degree(xv, breakpoint[2], breakpoint[3], breakpoint[4]);
         deg[4] = right_degree(xv, breakpoint[3], breakpoint[4]);
         expected_degrees.push_back(deg);
      endfunction

      task report_mismatch(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         mismatch_count++;
      endtask

      task check_result(degree_set_type got);
         degree_set_type want;
         if (expected_degrees.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected: %h", got));
            return;
         end
         want = expected_degrees.pop_front();
         for (int i = 0; i < LANE_COUNT; i++) begin
            if (got[i] !== want[i]) begin
               report_mismatch($sformatf("degree_%s got %0d want %0d",
                                         lane_name[i], got[i], want[i]));
            end
         end
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [SB-1:0]             req_sample;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [FB:0]               rsp_degree_first;
   logic [FB:0]               rsp_degree_second;
   logic [FB:0]               rsp_degree_third;
   logic [FB:0]               rsp_degree_fourth;
   logic [FB:0]               rsp_degree_fifth;
   logic                      csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [SB-1:0]             csr_data;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_cycles = 0;
   int cycle_count = 0;

   membership_scoreboard sb = new();

   five_set_fuzzy_membership_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_degree_first  (rsp_degree_first),
      .rsp_degree_second (rsp_degree_second),
      .rsp_degree_third  (rsp_degree_third),
      .rsp_degree_fourth (rsp_degree_fourth),
      .rsp_degree_fifth  (rsp_degree_fifth),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #1 clock = ~clock;

   // receiver: long hold-off counted here, otherwise random stall
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result({rsp_degree_fifth, rsp_degree_fourth, rsp_degree_third,
                          rsp_degree_second, rsp_degree_first});
      end
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("five_set_fuzzy_membership_top verification failed");
      $finish;
   end

   task send_sample(sample_type x);
      while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_sample <= x;
      do @(posedge clock); while (req_stall);
      sb.note_sample(x);
   endtask

   task write_reg(index_type idx, sample_type value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      sb.write_break(idx, value);
   endtask

   task drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_degrees.size() != 0) @(posedge clock);
      repeat (LATENCY + 3) @(negedge clock);
   endtask

   task run_phase(bit write_cfg, break_set_type cfg, bit touch_spare, int n_items,
                  int tx_pct, int rx_pct, int hold);
      int         r;
      int         k;
      int         t;
      sample_type lo;
      sample_type hi;
      sample_type x;
      drain();
      if (write_cfg) begin
         for (int i = 0; i < LANE_COUNT; i++) begin
            write_reg(index_type'(int'(fzm_pkg::REG_BREAK_ONE) + i), cfg[i]);
         end
         if (touch_spare) begin
            for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) begin
               write_reg(index_type'(i), sample_type'($urandom_range(65535)));
            end
         end
         @(negedge clock);
         csr_write <= 1'b0;
      end
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      hold_cycles = hold;
      repeat (n_items) begin
         r = $urandom_range(99);
         if (r < 45) begin
            x = sample_type'($urandom_range(65535));
         end else if (r < 85) begin
            // hug a breakpoint, clamped to the sample range
            k = $urandom_range(LANE_COUNT - 1);
            t = int'(sb.breakpoint[k]) + int'($urandom_range(8)) - 4;
            if (t < 0) t = 0;
            if (t > 65535) t = 65535;
            x = sample_type'(t);
         end else if (r < 95) begin
            k  = $urandom_range(LANE_COUNT - 2);
            lo = sb.breakpoint[k];
            hi = sb.breakpoint[k + 1];
            x  = (lo < hi) ? sample_type'($urandom_range(hi, lo)) : lo;
         end else begin
            case ($urandom_range(3))
               0: x = '0;
               1: x = sample_type'(1);
               2: x = '1 - 1'b1;
               default: x = '1;
            endcase
         end
         send_sample(x);
      end
   endtask

   initial begin
      break_set_type cfg;
      int            sorted_q [$];
      int            base;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_sample = '0;
      csr_write  = 1'b0;
      csr_index  = fzm_pkg::REG_BREAK_ONE;
      csr_data   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: range ends and both sides of every default breakpoint
      send_sample('0);
      send_sample(sample_type'(1));
      send_sample('1);
      for (int k = 0; k < LANE_COUNT; k++) begin
         for (int off = -1; off <= 1; off++) begin
            send_sample(sample_type'(sb.breakpoint[k] + off));
         end
      end
      run_phase(1'b0, '0, 1'b0, 40, 0, 0, 0);

      repeat (LANE_COUNT) sorted_q.push_back($urandom_range(65535));
      sorted_q.sort();
      for (int i = 0; i < LANE_COUNT; i++) cfg[i] = sample_type'(sorted_q[i]);
      run_phase(1'b1, cfg, 1'b0, 60, 58, 0, 0);

      run_phase(1'b1, '0, 1'b0, 55, 0, 58, 0);
      run_phase(1'b1, '1, 1'b0, 55, 22, 22, 0);

      // unordered breakpoints, spare indexes, and a long receiver hold-off
      for (int i = 0; i < LANE_COUNT; i++) cfg[i] = sample_type'($urandom_range(65535));
      run_phase(1'b1, cfg, 1'b1, 80, 0, 0, HOLD_LONG);

      // coincident breakpoints
      base   = $urandom_range(65533);
      cfg[0] = sample_type'(base);
      cfg[1] = sample_type'(base);
      cfg[2] = sample_type'(base + 1);
      cfg[3] = sample_type'(base + 1);
      cfg[4] = sample_type'(base + 2);
      run_phase(1'b1, cfg, 1'b0, 55, 22, 22, 0);

      cfg[0] = '0;
      cfg[1] = sample_type'(16384);
      cfg[2] = sample_type'(32768);
      cfg[3] = sample_type'(49152);
      cfg[4] = '1;
      run_phase(1'b1, cfg, 1'b0, 55, 58, 58, 0);

      drain();
      repeat (2 * LATENCY) @(posedge clock);
      if (sb.mismatch_count == 0) begin
         $display("five_set_fuzzy_membership_top verification clean");
      end else begin
         $display("five_set_fuzzy_membership_top verification failed");
      end
      $finish;
   end

endmodule
